@@ hw/rtl/swfs_pkg.sv @@
// Shared types and constants of the sliding window frame sender.
package swfs_pkg;

  // Input word: one local frame, one peer frame or one timer tick.
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] frame_id;
    logic [3:0]  length;
    logic [63:0] payload;
    logic [7:0]  peer_flags;
    logic [7:0]  peer_seq;
    logic [7:0]  peer_ack;
  } swfs_in_t;

  // Result word.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] out_id;
    logic [3:0]  out_length;
    logic [63:0] out_payload;
    logic [7:0]  out_flags;
    logic [7:0]  out_seq;
    logic [7:0]  out_ack;
    logic        last;
  } swfs_out_t;

  // One stored frame of the ring.
  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  length;
    logic [63:0] payload;
  } swfs_entry_t;

  // Operation codes; the fourth code is ignored.
  localparam logic [1:0] OP_LOCAL   = 2'd0;
  localparam logic [1:0] OP_PEER    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_NEW     = 3'd0;
  localparam logic [2:0] KIND_RESEND  = 3'd1;
  localparam logic [2:0] KIND_SEQ_ERR = 3'd2;
  localparam logic [2:0] KIND_FORWARD = 3'd3;
  localparam logic [2:0] KIND_ACK_ERR = 3'd4;
  localparam logic [2:0] KIND_DROP    = 3'd5;

  // Peer flag bits.
  localparam int FLAG_DATA_BIT = 0;
  localparam int FLAG_ACK_BIT  = 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_FLIGHT = 2'd1;
  localparam logic [7:0] RESEND_TICKS_RESET  = 8'd30;
  localparam logic [3:0] MAX_IN_FLIGHT_RESET = 4'd3;

  // Fixed frame values.
  localparam logic [31:0] ERROR_FRAME_ID = 32'hA000_0001;
  localparam logic [7:0]  PEER_FLAGS     = 8'd1;
  localparam logic [7:0]  SEQ_RESET      = 8'd1;

  // Read address selection of the ring store.
  localparam logic [1:0] RD_ACK    = 2'd0;
  localparam logic [1:0] RD_SEARCH = 2'd1;
  localparam logic [1:0] RD_SEND   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_in;
    logic       queue_write;
    logic       age_timers;
    logic       search_start;
    logic       search_next;
    logic       ack_release;
    logic       emit;
    logic [2:0] emit_kind;
    logic       rx_update;
    logic       send_commit;
    logic       resend_commit;
    logic       flush;
    logic [1:0] rd_sel;
  } swfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       ring_full;
    logic       ack_pending;
    logic       data_flag;
    logic       seq_match;
    logic       search_last;
    logic       rx_mismatch;
    logic       can_send;
    logic       head_expired;
    logic       can_emit;
  } swfs_status_t;

endpackage

@@ hw/rtl/sliding_window_frame_sender.sv @@
// Top level of the sliding window frame sender.
// Each input word is handled one at a time and yields up to five result words.
// An input passes the event step; a peer word then runs the ack search when an
// ack is pending, comparing up to SLOTS entries in flight one by one, and the
// data step, which may forward a data frame. All but ignored words then pass
// the send, timeout and flush steps. Any step that emits waits while the
// result side stalls. The search sets the worst case, as it walks the entries
// through the single read port of the ring store, shared in turn with the send
// and resend steps. A result word waits in a pending register until its last
// flag is known; the next input enters while the final word sits in the output
// register. Registers: index 0 resend tick count, index 1 max_in_flight.
module sliding_window_frame_sender #(
  parameter int SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swfs_pkg::swfs_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swfs_pkg::swfs_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [swfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  swfs_pkg::swfs_cmd_t    cmd;
  swfs_pkg::swfs_status_t status;

  swfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  swfs_dp #(.SLOTS(SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/swfs_dp.sv @@
// Datapath of the frame sender: ring store, timers, counters and result registers.
module swfs_dp #(
  parameter int SLOTS = 8,
  localparam int PW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  swfs_pkg::swfs_in_t             in_data,
  input  swfs_pkg::swfs_cmd_t            cmd,
  output swfs_pkg::swfs_status_t         status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output swfs_pkg::swfs_out_t            out_data
);

  swfs_pkg::swfs_in_t   in_r;
  logic [7:0]           resend_ticks_r;
  logic [3:0]           max_in_flight_r;
  logic [PW-1:0]        ack_ptr_r, send_ptr_r, wr_ptr_r, idx_r;
  logic [CW-1:0]        waiting_r, inflight_r;
  logic [7:0]           tx_seq_r, rx_exp_r;
  logic [7:0]           timer_r [SLOTS];
  swfs_pkg::swfs_entry_t data_mem [SLOTS];
  logic [7:0]           seq_mem [SLOTS];
  swfs_pkg::swfs_entry_t rd_entry_r;
  logic [7:0]           rd_seq_r;
  swfs_pkg::swfs_out_t  pend_r, out_r, new_res, pend_last;
  logic                 pend_v_r, out_valid_r;
  logic [PW-1:0]        rd_addr, search_addr, release_ptr;
  logic [PW:0]          search_sum, release_sum;
  logic [7:0]           ack_target;

  // Ring pointer arithmetic with one correction step.
  assign search_sum  = {1'b0, ack_ptr_r} + {1'b0, idx_r};
  assign release_sum = {1'b0, ack_ptr_r} + {1'b0, idx_r} + (PW+1)'(1);
  assign search_addr = (search_sum >= (PW+1)'(SLOTS)) ?
                       PW'(search_sum - (PW+1)'(SLOTS)) : search_sum[PW-1:0];
  assign release_ptr = (release_sum >= (PW+1)'(SLOTS)) ?
                       PW'(release_sum - (PW+1)'(SLOTS)) : release_sum[PW-1:0];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(SLOTS - 1)) ? '0 : p + PW'(1);
  endfunction

  assign ack_target = in_r.peer_ack - 8'd1;

  // Read address of the ring store.
  always_comb begin
    case (cmd.rd_sel)
      swfs_pkg::RD_SEARCH: rd_addr = search_addr;
      swfs_pkg::RD_SEND:   rd_addr = send_ptr_r;
      default:             rd_addr = ack_ptr_r;
    endcase
  end

  // Ring store: frame data written on queueing, sequence written on sending.
  always_ff @(posedge clk) begin
    if (cmd.queue_write) begin
      data_mem[wr_ptr_r] <= '{id: in_r.frame_id, length: in_r.length,
                              payload: in_r.payload};
    end
    if (cmd.send_commit) begin
      seq_mem[send_ptr_r] <= tx_seq_r;
    end
    rd_entry_r <= data_mem[rd_addr];
    rd_seq_r   <= seq_mem[rd_addr];
  end

  // Status to the controller.
  always_comb begin
    status.op           = in_r.operation;
    status.ring_full    = (waiting_r + inflight_r) == CW'(SLOTS);
    status.ack_pending  = in_r.peer_flags[swfs_pkg::FLAG_ACK_BIT] && (inflight_r != '0);
    status.data_flag    = in_r.peer_flags[swfs_pkg::FLAG_DATA_BIT];
    status.seq_match    = rd_seq_r == ack_target;
    status.search_last  = (CW'(idx_r) + CW'(1)) == inflight_r;
    status.rx_mismatch  = rx_exp_r != in_r.peer_seq;
    status.can_send     = (waiting_r != '0) && (8'(inflight_r) < 8'(max_in_flight_r));
    status.head_expired = (inflight_r != '0) && (timer_r[ack_ptr_r] == 8'd0);
    status.can_emit     = !pend_v_r || !out_valid_r || out_ready;
  end

  // Result word for the requested kind.
  always_comb begin
    new_res = '0;
    new_res.kind = cmd.emit_kind;
    case (cmd.emit_kind)
      swfs_pkg::KIND_NEW, swfs_pkg::KIND_RESEND: begin
        new_res.out_id      = rd_entry_r.id;
        new_res.out_length  = rd_entry_r.length;
        new_res.out_payload = rd_entry_r.payload;
        new_res.out_flags   = swfs_pkg::PEER_FLAGS;
        new_res.out_seq     = (cmd.emit_kind == swfs_pkg::KIND_NEW) ? tx_seq_r : rd_seq_r;
        new_res.out_ack     = rx_exp_r;
      end
      swfs_pkg::KIND_SEQ_ERR: begin
        new_res.out_id = swfs_pkg::ERROR_FRAME_ID;
      end
      swfs_pkg::KIND_FORWARD: begin
        new_res.out_id      = in_r.frame_id;
        new_res.out_length  = in_r.length;
        new_res.out_payload = in_r.payload;
        new_res.out_flags   = in_r.peer_flags;
        new_res.out_seq     = in_r.peer_seq;
        new_res.out_ack     = in_r.peer_ack;
      end
      swfs_pkg::KIND_ACK_ERR: begin
        new_res.out_seq = ack_target;
        new_res.out_ack = in_r.peer_ack;
      end
      swfs_pkg::KIND_DROP: begin
        new_res.out_id      = in_r.frame_id;
        new_res.out_length  = in_r.length;
        new_res.out_payload = in_r.payload;
      end
      default: begin
        new_res.kind = cmd.emit_kind;
      end
    endcase
  end

  // Input word and configuration registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_data;
    end
    if (!rst_n) begin
      resend_ticks_r  <= swfs_pkg::RESEND_TICKS_RESET;
      max_in_flight_r <= swfs_pkg::MAX_IN_FLIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        swfs_pkg::CFG_RESEND_TICKS:  resend_ticks_r  <= cfg_wdata;
        swfs_pkg::CFG_MAX_IN_FLIGHT: max_in_flight_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Pointers, counters and sequence numbers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_ptr_r  <= '0;
      send_ptr_r <= '0;
      wr_ptr_r   <= '0;
      idx_r      <= '0;
      waiting_r  <= '0;
      inflight_r <= '0;
      tx_seq_r   <= swfs_pkg::SEQ_RESET;
      rx_exp_r   <= swfs_pkg::SEQ_RESET;
    end else begin
      if (cmd.queue_write) begin
        wr_ptr_r  <= ptr_inc(wr_ptr_r);
        waiting_r <= waiting_r + CW'(1);
      end
      if (cmd.search_start) begin
        idx_r <= '0;
      end else if (cmd.search_next) begin
        idx_r <= idx_r + PW'(1);
      end
      if (cmd.ack_release) begin
        ack_ptr_r  <= release_ptr;
        inflight_r <= inflight_r - (CW'(idx_r) + CW'(1));
      end
      if (cmd.rx_update) begin
        rx_exp_r <= in_r.peer_seq + 8'd1;
      end
      if (cmd.send_commit) begin
        send_ptr_r <= ptr_inc(send_ptr_r);
        waiting_r  <= waiting_r - CW'(1);
        inflight_r <= inflight_r + CW'(1);
        tx_seq_r   <= tx_seq_r + 8'd1;
      end
    end
  end

  // Entry timers: aged together on a tick, reloaded on send and resend.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        timer_r[i] <= 8'd0;
      end
    end else begin
      if (cmd.age_timers) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (timer_r[i] != 8'd0) begin
            timer_r[i] <= timer_r[i] - 8'd1;
          end
        end
      end
      if (cmd.send_commit) begin
        timer_r[send_ptr_r] <= resend_ticks_r;
      end
      if (cmd.resend_commit) begin
        timer_r[ack_ptr_r] <= resend_ticks_r;
      end
    end
  end

  // The pending word marked as the final one of its input.
  always_comb begin
    pend_last      = pend_r;
    pend_last.last = 1'b1;
  end

  // Pending word and output register: a word is held back until it is known
  // whether it is the last one of its input.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend_r   <= new_res;
        pend_v_r <= 1'b1;
        if (pend_v_r) begin
          out_r       <= pend_r;
          out_valid_r <= 1'b1;
        end else if (out_valid_r && out_ready) begin
          out_valid_r <= 1'b0;
        end
      end else if (cmd.flush && pend_v_r) begin
        out_r       <= pend_last;
        out_valid_r <= 1'b1;
        pend_v_r    <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on ring occupancy, the ack release and the result hand-over.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (8'(waiting_r) + 8'(inflight_r)) <= 8'(SLOTS))
    else $error("ring occupancy above its size");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.flush) |-> status.can_emit)
    else $error("word pushed while the output register is still full");
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && !cmd.emit) |=> !pend_v_r)
    else $error("pending word kept after flush");
  a_release_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ack_release |-> (CW'(idx_r) < inflight_r))
    else $error("ack releases more words than are in flight");

endmodule

@@ hw/rtl/swfs_ctrl.sv @@
// Controller state machine of the frame sender.
module swfs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  swfs_pkg::swfs_status_t status,
  output swfs_pkg::swfs_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EVENT    = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CMP = 4'd3;
  localparam logic [3:0] S_DATA     = 4'd4;
  localparam logic [3:0] S_FWD      = 4'd5;
  localparam logic [3:0] S_SEND     = 4'd6;
  localparam logic [3:0] S_SEND_EM  = 4'd7;
  localparam logic [3:0] S_TO       = 4'd8;
  localparam logic [3:0] S_TO_EM    = 4'd9;
  localparam logic [3:0] S_FLUSH    = 4'd10;

  logic [3:0] state_r, state_nxt;

  // Sequencing of one input: event, ack search, data, send, timeout, flush.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EVENT;
        end
      end
      S_EVENT: begin
        case (status.op)
          swfs_pkg::OP_LOCAL: begin
            if (!status.ring_full) begin
              cmd.queue_write = 1'b1;
              state_nxt       = S_SEND;
            end else if (status.can_emit) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = swfs_pkg::KIND_DROP;
              state_nxt     = S_SEND;
            end
          end
          swfs_pkg::OP_PEER: begin
            if (status.ack_pending) begin
              cmd.search_start = 1'b1;
              state_nxt        = S_SRCH_RD;
            end else begin
              state_nxt = S_DATA;
            end
          end
          swfs_pkg::OP_TICK: begin
            cmd.age_timers = 1'b1;
            state_nxt      = S_SEND;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SRCH_RD: begin
        cmd.rd_sel = swfs_pkg::RD_SEARCH;
        state_nxt  = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd.rd_sel = swfs_pkg::RD_SEARCH;
        if (status.seq_match) begin
          cmd.ack_release = 1'b1;
          state_nxt       = S_DATA;
        end else if (status.search_last) begin
          if (status.can_emit) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = swfs_pkg::KIND_ACK_ERR;
            state_nxt     = S_DATA;
          end
        end else begin
          cmd.search_next = 1'b1;
          state_nxt       = S_SRCH_RD;
        end
      end
      S_DATA: begin
        if (!status.data_flag) begin
          state_nxt = S_SEND;
        end else if (!status.rx_mismatch) begin
          state_nxt = S_FWD;
        end else if (status.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = swfs_pkg::KIND_SEQ_ERR;
          state_nxt     = S_FWD;
        end
      end
      S_FWD: begin
        if (status.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = swfs_pkg::KIND_FORWARD;
          cmd.rx_update = 1'b1;
          state_nxt     = S_SEND;
        end
      end
      S_SEND: begin
        cmd.rd_sel = swfs_pkg::RD_SEND;
        state_nxt  = status.can_send ? S_SEND_EM : S_TO;
      end
      S_SEND_EM: begin
        cmd.rd_sel = swfs_pkg::RD_SEND;
        if (status.can_emit) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = swfs_pkg::KIND_NEW;
          cmd.send_commit = 1'b1;
          state_nxt       = S_TO;
        end
      end
      S_TO: begin
        cmd.rd_sel = swfs_pkg::RD_ACK;
        state_nxt  = status.head_expired ? S_TO_EM : S_FLUSH;
      end
      S_TO_EM: begin
        cmd.rd_sel = swfs_pkg::RD_ACK;
        if (status.can_emit) begin
          cmd.emit          = 1'b1;
          cmd.emit_kind     = swfs_pkg::KIND_RESEND;
          cmd.resend_commit = 1'b1;
          state_nxt         = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status.can_emit) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing checks.
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && cmd.flush))
    else $error("emit and flush in the same cycle");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVENT))
    else $error("accepted word did not start the event step");
  a_release_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ack_release |=> (state_r == S_DATA))
    else $error("ack search did not end after a release");

endmodule

@@ tb/sv/tb_sliding_window_frame_sender.sv @@
// Testbench of the sliding window frame sender: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb_sliding_window_frame_sender;

  localparam int RING     = 8;
  localparam int QUIET_LIM = 4000;
  localparam int SETTLE   = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  swfs_pkg::swfs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  swfs_pkg::swfs_out_t out_data;
  logic cfg_we = 1'b0;
  logic [swfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [swfs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  sliding_window_frame_sender #(.SLOTS(RING)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Predictor state: a private copy of the ring and its counters.
  logic [31:0] ring_id [RING];
  logic [3:0]  ring_len [RING];
  logic [63:0] ring_pay [RING];
  logic [7:0]  ring_seq [RING];
  logic [7:0]  ring_timer [RING];
  int          ack_ptr, send_ptr, wr_ptr, queued_cnt, flying_cnt;
  logic [7:0]  tx_seq, rx_exp, timeout_ticks;
  logic [3:0]  window_size;

  swfs_pkg::swfs_out_t expected_frames[$];
  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  quiet_cycles = 0;

  function automatic swfs_pkg::swfs_out_t frame(logic [2:0] k, logic [31:0] id,
                                                logic [3:0] len, logic [63:0] pay,
                                                logic [7:0] fl, logic [7:0] sq,
                                                logic [7:0] ak);
    swfs_pkg::swfs_out_t r;
    r.kind = k; r.out_id = id; r.out_length = len; r.out_payload = pay;
    r.out_flags = fl; r.out_seq = sq; r.out_ack = ak; r.last = 1'b0;
    return r;
  endfunction

  // Reset state of the predictor.
  task automatic reset_predictor();
    for (int i = 0; i < RING; i++) ring_timer[i] = 8'd0;
    ack_ptr = 0; send_ptr = 0; wr_ptr = 0; queued_cnt = 0; flying_cnt = 0;
    tx_seq = swfs_pkg::SEQ_RESET; rx_exp = swfs_pkg::SEQ_RESET;
    timeout_ticks = swfs_pkg::RESEND_TICKS_RESET;
    window_size = swfs_pkg::MAX_IN_FLIGHT_RESET;
  endtask

  // Works out every result word that one accepted input word causes.
  task automatic predict_frames(input swfs_pkg::swfs_in_t w);
    swfs_pkg::swfs_out_t r[$];
    logic [7:0] target;
    int hit;
    int p;
    if (w.operation == swfs_pkg::OP_IGNORED) return;
    if (w.operation == swfs_pkg::OP_LOCAL) begin
      if (queued_cnt + flying_cnt < RING) begin
        ring_id[wr_ptr] = w.frame_id; ring_len[wr_ptr] = w.length;
        ring_pay[wr_ptr] = w.payload;
        wr_ptr = (wr_ptr + 1) % RING; queued_cnt++;
      end else begin
        r.push_back(frame(swfs_pkg::KIND_DROP, w.frame_id, w.length, w.payload, 0, 0, 0));
      end
    end else if (w.operation == swfs_pkg::OP_PEER) begin
      if (w.peer_flags[swfs_pkg::FLAG_ACK_BIT] && flying_cnt > 0) begin
        target = w.peer_ack - 8'd1;
        hit = -1;
        for (int i = 0; i < flying_cnt; i++)
          if (hit < 0 && ring_seq[(ack_ptr + i) % RING] == target) hit = i;
        if (hit >= 0) begin
          ack_ptr = (ack_ptr + hit + 1) % RING; flying_cnt -= hit + 1;
        end else begin
          r.push_back(frame(swfs_pkg::KIND_ACK_ERR, 0, 0, 0, 0, target, w.peer_ack));
        end
      end
      if (w.peer_flags[swfs_pkg::FLAG_DATA_BIT]) begin
        if (rx_exp != w.peer_seq)
          r.push_back(frame(swfs_pkg::KIND_SEQ_ERR, swfs_pkg::ERROR_FRAME_ID, 0, 0, 0, 0, 0));
        rx_exp = w.peer_seq + 8'd1;
        r.push_back(frame(swfs_pkg::KIND_FORWARD, w.frame_id, w.length, w.payload,
                          w.peer_flags, w.peer_seq, w.peer_ack));
      end
    end else begin
      for (int i = 0; i < RING; i++) if (ring_timer[i] != 0) ring_timer[i]--;
    end
    // Send stage.
    if (queued_cnt > 0 && flying_cnt < window_size) begin
      p = send_ptr;
      ring_seq[p] = tx_seq; tx_seq++;
      send_ptr = (send_ptr + 1) % RING; queued_cnt--; flying_cnt++;
      ring_timer[p] = timeout_ticks;
      r.push_back(frame(swfs_pkg::KIND_NEW, ring_id[p], ring_len[p], ring_pay[p],
                        swfs_pkg::PEER_FLAGS, ring_seq[p], rx_exp));
    end
    // Timeout of the oldest frame in flight.
    if (flying_cnt > 0 && ring_timer[ack_ptr] == 0) begin
      p = ack_ptr;
      ring_timer[p] = timeout_ticks;
      r.push_back(frame(swfs_pkg::KIND_RESEND, ring_id[p], ring_len[p], ring_pay[p],
                        swfs_pkg::PEER_FLAGS, ring_seq[p], rx_exp));
    end
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    foreach (r[i]) expected_frames.push_back(r[i]);
  endtask

  // Offers one word, with random idle cycles ahead of it, and waits for it to go in.
  task automatic send_word(input swfs_pkg::swfs_in_t w);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frames(w);
  endtask

  // Waits until every expected word has arrived and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; only called while idle.
  task automatic set_registers(input logic [7:0] to, input logic [7:0] mif);
    cfg_we <= 1'b1; cfg_index <= swfs_pkg::CFG_RESEND_TICKS; cfg_wdata <= to;
    @(posedge clk);
    timeout_ticks = to;
    cfg_index <= swfs_pkg::CFG_MAX_IN_FLIGHT; cfg_wdata <= mif;
    @(posedge clk);
    window_size = mif[3:0];
    cfg_we <= 1'b0;
  endtask

  function automatic swfs_pkg::swfs_in_t word(logic [1:0] op, logic [31:0] id,
                                              logic [3:0] len, logic [63:0] pay,
                                              logic [7:0] fl, logic [7:0] sq,
                                              logic [7:0] ak);
    swfs_pkg::swfs_in_t w;
    w.operation = op; w.frame_id = id; w.length = len; w.payload = pay;
    w.peer_flags = fl; w.peer_seq = sq; w.peer_ack = ak;
    return w;
  endfunction

  // Random word, mostly well formed: acks name frames in flight, data follows the sequence.
  function automatic swfs_pkg::swfs_in_t random_word();
    swfs_pkg::swfs_in_t w;
    int pick;
    w = word(swfs_pkg::OP_LOCAL, $urandom, 4'($urandom_range(0, 15)), {$urandom, $urandom},
             8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 3) != 0) w.length = 4'($urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.operation = swfs_pkg::OP_LOCAL;
    end else if (pick < 67) begin
      w.operation = swfs_pkg::OP_PEER;
      if ($urandom_range(0, 4) != 0) w.peer_flags[1:0] = 2'($urandom_range(1, 3));
      if (flying_cnt > 0 && $urandom_range(0, 3) != 0)
        w.peer_ack = ring_seq[(ack_ptr + $urandom_range(0, flying_cnt - 1)) % RING] + 8'd1;
      if ($urandom_range(0, 4) != 0) w.peer_seq = rx_exp;
    end else if (pick < 96) begin
      w.operation = swfs_pkg::OP_TICK;
    end else begin
      w.operation = swfs_pkg::OP_IGNORED;
    end
    return w;
  endfunction

  // Runs a number of random words under one register setting and idling pattern.
  task automatic test_random(input int count, input logic [7:0] to, input logic [7:0] mif,
                             input int idle_pct, input int stall);
    swfs_pkg::swfs_in_t w;
    int done;
    wait_idle();
    set_registers(to, mif);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    done = 0;
    while (done < count) begin
      w = random_word();
      send_word(w);
      if (w.operation != swfs_pkg::OP_IGNORED) done++;
    end
  endtask

  // Directed words: field extremes, every operation and the named corner cases.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_word(word(swfs_pkg::OP_LOCAL, 32'hFFFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF,
                   8'hFF, 8'hFF, 8'hFF));
    send_word(word(swfs_pkg::OP_LOCAL, 32'h0, 4'h0, 64'h0, 8'h0, 8'h0, 8'h0));
    send_word(word(swfs_pkg::OP_LOCAL, 32'h1234_5678, 4'd8, 64'h0123_4567_89AB_CDEF,
                   0, 0, 0));
    send_word(word(swfs_pkg::OP_PEER, 32'h55, 4'd1, 64'h1, 8'h02, 8'h00, 8'h02));
    send_word(word(swfs_pkg::OP_PEER, 32'h66, 4'd2, 64'h2, 8'h02, 8'h00, 8'h77));
    send_word(word(swfs_pkg::OP_PEER, 32'h77, 4'd3, 64'h3, 8'h01, 8'h01, 8'h00));
    send_word(word(swfs_pkg::OP_PEER, 32'h88, 4'd4, 64'h4, 8'hFD, 8'h09, 8'h00));
    send_word(word(swfs_pkg::OP_PEER, 32'h99, 4'd5, 64'h5, 8'hFF, 8'h00, 8'h04));
    send_word(word(swfs_pkg::OP_PEER, 32'hAA, 4'd6, 64'h6, 8'h03, 8'h01, 8'h04));
    send_word(word(swfs_pkg::OP_IGNORED, 32'hFFFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF,
                   8'hFF, 8'hFF, 8'hFF));
    wait_idle();
    set_registers(8'd1, 8'd2);
    send_word(word(swfs_pkg::OP_LOCAL, 32'hC0DE, 4'd7, 64'hAAAA_5555_AAAA_5555, 0, 0, 0));
    send_word(word(swfs_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
    send_word(word(swfs_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
    wait_idle();
    set_registers(8'd0, 8'd0);
    send_word(word(swfs_pkg::OP_TICK, 0, 0, 0, 0, 0, 0));
    send_word(word(swfs_pkg::OP_LOCAL, 32'hBEEF, 4'd2, 64'h5555, 0, 0, 0));
    // Ack that names the frame still in flight releases it.
    send_word(word(swfs_pkg::OP_PEER, 32'h1, 4'd0, 64'h0, 8'h02, 8'h00, 8'h05));
  endtask

  // Ring full: a stopped window lets the ring fill until local words are dropped.
  task automatic test_ring_full();
    wait_idle();
    set_registers(8'd255, 8'h0);
    send_idle_pct = 15;
    stall_pct = 15;
    for (int i = 0; i < 12; i++)
      send_word(word(swfs_pkg::OP_LOCAL, $urandom, 4'($urandom_range(0, 8)),
                     {$urandom, $urandom}, 0, 0, 0));
  endtask

  // Receiver: random stalls, and each accepted word checked against the oldest expectation.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", out_data);
      end else begin
        if (out_data.kind !== expected_frames[0].kind ||
            out_data.out_id !== expected_frames[0].out_id ||
            out_data.out_length !== expected_frames[0].out_length ||
            out_data.out_payload !== expected_frames[0].out_payload ||
            out_data.out_flags !== expected_frames[0].out_flags ||
            out_data.out_seq !== expected_frames[0].out_seq ||
            out_data.out_ack !== expected_frames[0].out_ack ||
            out_data.last !== expected_frames[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", expected_frames[0], out_data);
        end
        void'(expected_frames.pop_front());
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIM) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_ring_full();
    test_random(60, 8'd4, 8'd3, 0, 0);
    test_random(60, 8'd1, {4'hA, 4'd8}, 65, 0);
    test_random(50, 8'd0, {4'h5, 4'd2}, 0, 65);
    test_random(40, 8'd255, 8'd1, 15, 15);
    test_random(40, 8'd6, 8'hF5, 15, 15);
    wait_idle();
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
